// File: rtl/rmst_pkg.sv
// shared types, constants and codes for the range maximum segment tree
package rmst_pkg;

    // default number of leaves
    localparam int unsigned LEAVES_DEF = 1024;

    // field widths
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned LEAF_W  = 10;
    localparam int unsigned RANGE_W = 11;

    // value every node holds after reset
    localparam logic signed [VAL_W-1:0] SENTINEL = -32'sh7F00_0000;

    // request action codes
    localparam logic ACT_RAISE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // one request
    typedef struct packed {
        logic                      action;
        logic [LEAF_W-1:0]         leaf_index;
        logic signed [VAL_W-1:0]   new_value;
        logic [RANGE_W-1:0]        range_from;
        logic [RANGE_W-1:0]        range_to;
    } req_t;

    // one query result
    typedef struct packed {
        logic signed [VAL_W-1:0]   range_max;
        logic                      range_empty;
    } res_t;

endpackage

// File: rtl/rmst_node_ram.sv
// tree node memory, one write port and one registered read port
module rmst_node_ram #(
    parameter int unsigned DEPTH = 2 * rmst_pkg::LEAVES_DEF
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [$clog2(DEPTH)-1:0]                 waddr,
    input  logic signed [rmst_pkg::VAL_W-1:0]        wdata,
    input  logic                                     re,
    input  logic [$clog2(DEPTH)-1:0]                 raddr,
    output logic signed [rmst_pkg::VAL_W-1:0]        rdata
);
    import rmst_pkg::*;

    logic signed [VAL_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/range_max_segment_tree.sv
// range maximum segment tree with point raise, sequencer and shared max unit
//
//   channel  | signals                  | moves
//   ---------+--------------------------+-------------------------------------
//   request  | req_valid, req_ready, req | raise (no result) or range query
//   result   | res_valid, res_ready, res | maximum over range, empty flag
//
// after reset a clearing pass writes the sentinel into all 2*LEAVES nodes,
// one per cycle; no request is taken meanwhile. a raise makes one node write
// per level. a query uses two slots per level on the single read port of the
// node memory, each merged by the max unit.
// the result sits in an output register; a stalled result holds the next query
// at its end, while a raise still runs through.
module range_max_segment_tree #(
    parameter int unsigned LEAVES = rmst_pkg::LEAVES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rmst_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_ready,
    output rmst_pkg::res_t res
);
    import rmst_pkg::*;

    localparam int unsigned NODES = 2 * LEAVES;
    localparam int unsigned AW    = $clog2(NODES);
    localparam int unsigned NW    = AW + 1;
    localparam int unsigned CW    = (NW > RANGE_W) ? NW : RANGE_W;

    localparam logic [AW-1:0] NODE_LAST  = AW'(NODES - 1);
    localparam logic [NW-1:0] LEAF_BASE  = NW'(LEAVES);
    localparam logic [CW-1:0] LEAVES_CMP = CW'(LEAVES);

    typedef enum logic [5:0] {
        ST_CLR   = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_RAISE = 6'b000100,
        ST_QLO   = 6'b001000,
        ST_QHI   = 6'b010000,
        ST_QFIN  = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [NW-1:0]           node_reg, node_next;
    logic [NW-1:0]           hi_reg, hi_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic                    pend_reg, pend_next;
    logic                    res_valid_reg, res_valid_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic signed [VAL_W-1:0] best_reg, best_next;
    logic                    empty_reg, empty_next;
    res_t                    res_reg, res_next;

    // memory ports
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic signed [VAL_W-1:0] mem_rdata;

    // shared max unit
    logic signed [VAL_W-1:0] max_b;
    logic signed [VAL_W-1:0] max_y;

    // request decode helpers
    logic [CW-1:0]           from_x, to_x, from_c, to_c, idx_x;
    logic [NW-1:0]           leaf_node, hi_dec, hi_use, k_up;

    rmst_node_ram #(
        .DEPTH (NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // max of read data and either raise value or running best
    assign max_b = (state_reg == ST_RAISE) ? val_reg : best_reg;
    assign max_y = (mem_rdata > max_b) ? mem_rdata : max_b;

    // clamp query bounds and form the leaf node of a raise
    always_comb
    begin
        from_x    = CW'(req.range_from);
        to_x      = CW'(req.range_to);
        idx_x     = CW'(req.leaf_index);
        from_c    = (from_x > LEAVES_CMP) ? LEAVES_CMP : from_x;
        to_c      = (to_x > LEAVES_CMP) ? LEAVES_CMP : to_x;
        leaf_node = LEAF_BASE + NW'(idx_x);
    end

    assign hi_dec = hi_reg - NW'(1);
    assign hi_use = hi_reg[0] ? hi_dec : hi_reg;
    assign k_up   = node_reg >> 1;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        hi_next        = hi_reg;
        clr_next       = clr_reg;
        pend_next      = 1'b0;
        val_next       = val_reg;
        empty_next     = empty_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        mem_we         = 1'b0;
        mem_waddr      = node_reg[AW-1:0];
        mem_wdata      = max_y;
        mem_re         = 1'b0;
        mem_raddr      = node_reg[AW-1:0];

        // merge a node read in the previous cycle
        best_next = pend_reg ? max_y : best_reg;

        unique case (state_reg)
            ST_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = SENTINEL;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == NODE_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.action == ACT_QUERY)
                    begin
                        node_next  = LEAF_BASE + NW'(from_c);
                        hi_next    = LEAF_BASE + NW'(to_c);
                        best_next  = SENTINEL;
                        empty_next = (req.range_from >= req.range_to);
                        state_next = ST_QLO;
                    end
                    else if (idx_x < LEAVES_CMP)
                    begin
                        node_next  = leaf_node;
                        val_next   = req.new_value;
                        mem_re     = 1'b1;
                        mem_raddr  = leaf_node[AW-1:0];
                        state_next = ST_RAISE;
                    end
                end
            end
            ST_RAISE:
            begin
                // write this level, read its parent in the same cycle
                mem_we    = 1'b1;
                mem_waddr = node_reg[AW-1:0];
                mem_wdata = max_y;
                node_next = k_up;
                if (k_up == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = k_up[AW-1:0];
                end
            end
            ST_QLO:
            begin
                if (node_reg < hi_reg)
                begin
                    if (node_reg[0])
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = node_reg[AW-1:0];
                        pend_next = 1'b1;
                        node_next = node_reg + NW'(1);
                    end
                    state_next = ST_QHI;
                end
                else
                begin
                    state_next = ST_QFIN;
                end
            end
            ST_QHI:
            begin
                if (hi_reg[0])
                begin
                    mem_re    = 1'b1;
                    mem_raddr = hi_dec[AW-1:0];
                    pend_next = 1'b1;
                end
                node_next  = k_up;
                hi_next    = hi_use >> 1;
                state_next = ST_QLO;
            end
            ST_QFIN:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next.range_max   = best_next;
                    res_next.range_empty = empty_reg;
                    res_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        hi_reg    <= hi_next;
        val_reg   <= val_next;
        best_reg  <= best_next;
        empty_reg <= empty_next;
        res_reg   <= res_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
